/* sv/lhsh_pkg.sv */
package lhsh_pkg;

	// Histogram geometry
	localparam int BINS_PER_AXIS = 256;
	localparam int COUNT_WIDTH   = 32;
	localparam int COORD_W       = 8;
	localparam int IDX_AW        = $clog2(BINS_PER_AXIS * BINS_PER_AXIS);
	localparam int MEM_AW        = IDX_AW + 1;
	localparam int MEM_DEPTH     = 1 << MEM_AW;

	// Result field widths
	localparam int FIELD_W = 32;
	localparam int LVL_W   = 8;
	localparam int LVL_N   = 1 << LVL_W;

	// Level scale: level = floor(LVL_SCALE * log2(count)), capped at LVL_N - 1
	localparam int LVL_SCALE = 20;
	// Smallest count that reaches the top level is 6889, which fits in 13 bits
	localparam int THR_W     = 13;
	localparam int POW_W     = 272;

	// Request codes
	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [LVL_N-1:0][THR_W-1:0] thr_tab_t;

	// Entry l holds the smallest count c with c^LVL_SCALE >= 2^l
	function automatic thr_tab_t build_thresh();
		thr_tab_t tab;
		logic [POW_W-1:0] pw;
		logic [POW_W-1:0] lim;
		int lo;
		int hi;
		int mid;
		for (int l = 0; l < LVL_N; l++) begin
			lo  = 1;
			hi  = 1 << THR_W;
			lim = POW_W'(1) << l;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				pw  = POW_W'(1);
				for (int k = 0; k < LVL_SCALE; k++) begin
					pw = pw * POW_W'(mid);
				end
				if (pw >= lim) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
			tab[l] = THR_W'(lo);
		end
		return tab;
	endfunction

	localparam thr_tab_t LVL_THRESH = build_thresh();

endpackage

/* sv/lhsh_if.sv */
interface lhsh_req_if;
	import lhsh_pkg::*;

	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [COORD_W-1:0] hue;
	logic [COORD_W-1:0] sat;
	logic               label;
	logic               last_pixel;

	modport source (output valid, output req_type, output hue, output sat, output label,
		output last_pixel, input ready);
	modport sink (input valid, input req_type, input hue, input sat, input label,
		input last_pixel, output ready);

endinterface

interface lhsh_res_if;
	import lhsh_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] bin_count;
	logic [LVL_W-1:0]   level;
	logic [FIELD_W-1:0] total_samples;
	logic [FIELD_W-1:0] max_count;
	logic               frame_done;

	modport source (output valid, output bin_count, output level, output total_samples,
		output max_count, output frame_done, input ready);
	modport sink (input valid, input bin_count, input level, input total_samples,
		input max_count, input frame_done, output ready);

endinterface

/* sv/lhsh_ram.sv */
module lhsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* sv/labeled_hue_sat_histogram_unit.sv */
// Channel | Modport | Transfer moves
// --------+---------+---------------------------------------------------------
// req     | sink    | req_type, hue, sat, label, last_pixel
// res     | source  | bin_count, level, total_samples, max_count, frame_done
//
// A request passes through accept, bin read-modify-write, 8 steps of the level
// search over the threshold table, and result load into the output register.
// Both histograms share one single-port-write RAM; the label picks its top half.
// After reset and after every clear request a sweep zeroes the RAM one entry a
// cycle, during which no request is accepted.
// A result waits in the output register while the next request is accepted.
module labeled_hue_sat_histogram_unit (
	input  logic clk,
	input  logic arst_n,
	lhsh_req_if.sink   req,
	lhsh_res_if.source res
);
	import lhsh_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_UPD   = 5'b00100,
		ST_LVL   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [MEM_AW-1:0]        clr_addr_q;
	logic [$clog2(LVL_W)-1:0] bit_q;
	cnt_t                     total_q;
	cnt_t                     pos_peak_q;
	cnt_t                     neg_peak_q;
	logic                     out_valid_q;

	logic [REQ_W-1:0]         req_q;
	logic [MEM_AW-1:0]        addr_q;
	logic                     inside_q;
	logic                     label_q;
	logic                     last_q;
	cnt_t                     cnt_q;
	logic [LVL_W-1:0]         lvl_q;

	cnt_t                     out_cnt_q;
	logic [LVL_W-1:0]         out_lvl_q;
	cnt_t                     out_total_q;
	cnt_t                     out_peak_q;
	logic                     out_last_q;

	logic                     accept;
	logic                     inside_in;
	logic [IDX_AW-1:0]        idx_in;
	logic [MEM_AW-1:0]        rd_addr;
	cnt_t                     rd_data;
	logic                     wr_en;
	logic [MEM_AW-1:0]        wr_addr;
	cnt_t                     wr_data;
	logic                     is_count;
	cnt_t                     cnt_inc;
	cnt_t                     cnt_new;
	cnt_t                     peak_sel;
	logic [LVL_W-1:0]         cand;
	logic                     out_load;

	// Input handshake and bin address
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	assign inside_in = ({1'b0, req.hue} < (COORD_W + 1)'(BINS_PER_AXIS)) &&
		({1'b0, req.sat} < (COORD_W + 1)'(BINS_PER_AXIS));
	assign idx_in = inside_in ?
		IDX_AW'(32'(req.hue) * 32'(BINS_PER_AXIS) + 32'(req.sat)) : '0;
	assign rd_addr = {req.label, idx_in};

	// Bin update
	assign is_count = (req_q == REQ_COUNT) && inside_q;
	assign cnt_inc  = (rd_data == '1) ? rd_data : rd_data + cnt_t'(1);
	assign peak_sel = label_q ? pos_peak_q : neg_peak_q;

	always_comb begin
		case (req_q)
			REQ_COUNT: cnt_new = inside_q ? cnt_inc : '0;
			REQ_CLEAR: cnt_new = '0;
			default:   cnt_new = inside_q ? rd_data : '0;
		endcase
	end

	// RAM write: sweep zeroes during clear, else write back the counted bin
	assign wr_en   = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && is_count);
	assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : cnt_inc;

	lhsh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (MEM_DEPTH)
	) u_bins (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Level search: set one bit of the level a cycle, MSB first
	assign cand     = lvl_q | (LVL_W'(1) << bit_q);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || res.ready);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			bit_q      <= '0;
			total_q    <= '0;
			pos_peak_q <= '0;
			neg_peak_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + MEM_AW'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (req_q == REQ_CLEAR) begin
						total_q    <= '0;
						pos_peak_q <= '0;
						neg_peak_q <= '0;
					end else if (is_count) begin
						if (total_q != '1) begin
							total_q <= total_q + cnt_t'(1);
						end
						if (cnt_inc > peak_sel) begin
							if (label_q) begin
								pos_peak_q <= cnt_inc;
							end else begin
								neg_peak_q <= cnt_inc;
							end
						end
					end
					bit_q   <= $clog2(LVL_W)'(LVL_W - 1);
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					if (bit_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						bit_q <= bit_q - $clog2(LVL_W)'(1);
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= (req_q == REQ_CLEAR) ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Request payload and working values
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req.req_type;
			addr_q   <= rd_addr;
			inside_q <= inside_in;
			label_q  <= req.label;
			last_q   <= req.last_pixel;
		end
		if (state_q == ST_UPD) begin
			cnt_q <= cnt_new;
			lvl_q <= '0;
		end else if (state_q == ST_LVL) begin
			if (FIELD_W'(cnt_q) >= FIELD_W'(LVL_THRESH[cand])) begin
				lvl_q <= cand;
			end
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cnt_q   <= cnt_q;
			out_lvl_q   <= lvl_q;
			out_total_q <= total_q;
			out_peak_q  <= peak_sel;
			out_last_q  <= last_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.bin_count     = FIELD_W'(out_cnt_q);
	assign res.level         = out_lvl_q;
	assign res.total_samples = FIELD_W'(out_total_q);
	assign res.max_count     = FIELD_W'(out_peak_q);
	assign res.frame_done    = out_last_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && (req_q == REQ_COUNT) |=> total_q >= $past(total_q))
		else $error("sample total dropped on a count request");

	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) && is_count |=> peak_sel >= cnt_q)
		else $error("peak below the bin just counted");

	a_sweep_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (total_q == '0) && (pos_peak_q == '0) &&
		(neg_peak_q == '0))
		else $error("total or peak not zero during clear sweep");

	a_hold_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LVL) |-> !accept && !wr_en)
		else $error("transfer or RAM write during level search");
`endif

endmodule

/* bench/tb_labeled_hue_sat_histogram_unit.sv */
module tb_labeled_hue_sat_histogram_unit;
	import lhsh_pkg::*;

	localparam int          NBINS       = BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int          RANDOM_REQS = 1780;
	localparam int          BURST_REQS  = 200;
	localparam int          HOT_BINS    = 8;
	localparam int          MAX_WAIT    = 19;
	localparam cnt_t        CNT_MAX     = '1;
	// Unused request code, handled as a read
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic [COORD_W-1:0] hue;
		logic [COORD_W-1:0] sat;
		logic               label;
		logic               last;
		int unsigned        gap;
	} pixel_req_t;

	typedef struct {
		cnt_t             bin_count;
		logic [LVL_W-1:0] level;
		cnt_t             total_samples;
		cnt_t             max_count;
		logic             frame_done;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lhsh_req_if req_ch ();
	lhsh_res_if res_ch ();

	labeled_hue_sat_histogram_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// Shadow histogram state
	cnt_t hist_bins [2][NBINS] = '{default: '0};
	cnt_t hist_peak [2] = '{default: '0};
	cnt_t pixel_total = '0;

	pixel_req_t  pending_reqs[$];
	bin_result_t expected_results[$];

	int          n_total;
	int          n_results = 0;
	int          n_errors = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left;
	bit          gen_calm;
	int unsigned gen_calm_left = 0;
	bit          mon_calm;
	int unsigned mon_calm_left = 0;
	logic [COORD_W-1:0] hot_hue [HOT_BINS];
	logic [COORD_W-1:0] hot_sat [HOT_BINS];

	always #6 clk = ~clk;

	// floor(20*log2(c)) capped at 255: bit length of c^20, minus one
	function automatic logic [LVL_W-1:0] log_level(cnt_t c);
		logic [279:0] pw;
		int unsigned  base;
		int           msb;
		if (c == '0) begin
			return '0;
		end
		base = (c > 8192) ? 8192 : c;
		pw   = 280'd1;
		repeat (LVL_SCALE) pw = pw * base;
		msb = 0;
		for (int i = 0; i < 280; i++) begin
			if (pw[i]) begin
				msb = i;
			end
		end
		return (msb > LVL_N - 1) ? LVL_W'(LVL_N - 1) : LVL_W'(msb);
	endfunction

	// Apply one request to the shadow histograms and form its result
	function automatic bin_result_t histogram_apply(logic [REQ_W-1:0] kind,
			logic [COORD_W-1:0] hue, logic [COORD_W-1:0] sat, logic label, logic last);
		bin_result_t r;
		int          idx;
		cnt_t        cnt;
		cnt = '0;
		idx = int'(hue) * BINS_PER_AXIS + int'(sat);
		if (kind == REQ_CLEAR) begin
			for (int i = 0; i < NBINS; i++) begin
				hist_bins[0][i] = '0;
				hist_bins[1][i] = '0;
			end
			hist_peak[0] = '0;
			hist_peak[1] = '0;
			pixel_total  = '0;
		end else if (hue < BINS_PER_AXIS && sat < BINS_PER_AXIS) begin
			if (kind == REQ_COUNT) begin
				if (hist_bins[label][idx] != CNT_MAX) begin
					hist_bins[label][idx] = hist_bins[label][idx] + cnt_t'(1);
				end
				if (pixel_total != CNT_MAX) begin
					pixel_total = pixel_total + cnt_t'(1);
				end
				if (hist_bins[label][idx] > hist_peak[label]) begin
					hist_peak[label] = hist_bins[label][idx];
				end
			end
			cnt = hist_bins[label][idx];
		end
		r.bin_count     = cnt;
		r.level         = log_level(cnt);
		r.total_samples = pixel_total;
		r.max_count     = hist_peak[label];
		r.frame_done    = last;
		return r;
	endfunction

	// Queue one request; the gap before it comes in calm or busy stretches
	task automatic add_req(logic [REQ_W-1:0] kind, logic [COORD_W-1:0] hue,
			logic [COORD_W-1:0] sat, logic label, logic last);
		pixel_req_t it;
		if (gen_calm_left == 0) begin
			gen_calm      = ($urandom_range(0, 2) == 0);
			gen_calm_left = $urandom_range(10, 80);
		end
		gen_calm_left--;
		it.kind  = kind;
		it.hue   = hue;
		it.sat   = sat;
		it.label = label;
		it.last  = last;
		it.gap   = gen_calm ? 0 : $urandom_range(0, MAX_WAIT);
		pending_reqs.push_back(it);
	endtask

	task automatic build_stimulus();
		int                 pick;
		int                 h;
		logic [REQ_W-1:0]   kind;
		logic [COORD_W-1:0] hue;
		logic [COORD_W-1:0] sat;
		// Directed: empty bin, grid corners, repeated bin, spare code, clear
		add_req(REQ_READ,  8'd0,   8'd0,   1'b0, 1'b0);
		add_req(REQ_COUNT, 8'd0,   8'd0,   1'b1, 1'b1);
		add_req(REQ_COUNT, 8'd0,   8'd0,   1'b1, 1'b0);
		add_req(REQ_COUNT, 8'd0,   8'd0,   1'b1, 1'b0);
		add_req(REQ_COUNT, 8'd255, 8'd255, 1'b0, 1'b0);
		add_req(REQ_COUNT, 8'd255, 8'd0,   1'b0, 1'b1);
		add_req(REQ_COUNT, 8'd0,   8'd255, 1'b1, 1'b0);
		add_req(REQ_COUNT, 8'd255, 8'd255, 1'b0, 1'b0);
		add_req(REQ_READ,  8'd0,   8'd0,   1'b1, 1'b0);
		add_req(REQ_READ,  8'd0,   8'd0,   1'b0, 1'b1);
		add_req(REQ_SPARE, 8'd255, 8'd255, 1'b0, 1'b1);
		add_req(REQ_SPARE, 8'd12,  8'd34,  1'b1, 1'b0);
		add_req(REQ_COUNT, 8'hAA,  8'h55,  1'b0, 1'b0);
		add_req(REQ_COUNT, 8'h55,  8'hAA,  1'b1, 1'b1);
		add_req(REQ_CLEAR, 8'hFF,  8'hFF,  1'b1, 1'b1);
		add_req(REQ_READ,  8'd0,   8'd0,   1'b1, 1'b0);
		add_req(REQ_READ,  8'd255, 8'd255, 1'b0, 1'b0);
		add_req(REQ_COUNT, 8'd7,   8'd9,   1'b0, 1'b0);
		add_req(REQ_READ,  8'd7,   8'd9,   1'b0, 1'b1);

		// Drive one bin into the hundreds
		for (int i = 0; i < BURST_REQS; i++) begin
			add_req(REQ_COUNT, 8'h5A, 8'hA5, 1'b1, (i % 97) == 0);
		end
		add_req(REQ_READ, 8'h5A, 8'hA5, 1'b1, 1'b1);
		add_req(REQ_READ, 8'h5A, 8'hA5, 1'b0, 1'b0);

		// Random: mostly counts and reads on a few hot bins, some scattered
		for (int i = 0; i < HOT_BINS; i++) begin
			hot_hue[i] = COORD_W'($urandom_range(0, 255));
			hot_sat[i] = COORD_W'($urandom_range(0, 255));
		end
		for (int i = 0; i < RANDOM_REQS; i++) begin
			pick = $urandom_range(0, 99);
			if (i == RANDOM_REQS / 2) begin
				kind = REQ_CLEAR;
			end else if (pick < 60) begin
				kind = REQ_COUNT;
			end else if (pick < 92) begin
				kind = REQ_READ;
			end else begin
				kind = REQ_SPARE;
			end
			if ($urandom_range(0, 9) < 7) begin
				h   = $urandom_range(0, HOT_BINS - 1);
				hue = hot_hue[h];
				sat = hot_sat[h];
			end else begin
				hue = COORD_W'($urandom_range(0, 255));
				sat = COORD_W'($urandom_range(0, 255));
			end
			add_req(kind, hue, sat, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Request driver: predict on each transfer, then present the next item
	always @(posedge clk or negedge arst_n) begin
		pixel_req_t nxt;
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.req_type   <= REQ_COUNT;
			req_ch.hue        <= '0;
			req_ch.sat        <= '0;
			req_ch.label      <= 1'b0;
			req_ch.last_pixel <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(histogram_apply(req_ch.req_type, req_ch.hue,
					req_ch.sat, req_ch.label, req_ch.last_pixel));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (pending_reqs[0].gap != 0) begin
					pending_reqs[0].gap = pending_reqs[0].gap - 1;
					req_ch.valid <= 1'b0;
				end else begin
					nxt = pending_reqs.pop_front();
					req_ch.valid      <= 1'b1;
					req_ch.req_type   <= nxt.kind;
					req_ch.hue        <= nxt.hue;
					req_ch.sat        <= nxt.sat;
					req_ch.label      <= nxt.label;
					req_ch.last_pixel <= nxt.last;
				end
			end
		end
	end

	// Result monitor: compare each transfer, then stall ready for a drawn time
	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		int unsigned pause;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					n_errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("bin_count", want.bin_count, res_ch.bin_count);
					check_field("level", 32'(want.level), 32'(res_ch.level));
					check_field("total_samples", want.total_samples, res_ch.total_samples);
					check_field("max_count", want.max_count, res_ch.max_count);
					check_field("frame_done", 32'(want.frame_done), 32'(res_ch.frame_done));
				end
				if (mon_calm_left == 0) begin
					mon_calm      = ($urandom_range(0, 2) == 0);
					mon_calm_left = $urandom_range(10, 80);
				end
				mon_calm_left--;
				pause = mon_calm ? 0 : $urandom_range(0, MAX_WAIT);
				stall_left   <= pause;
				res_ch.ready <= (pause == 0);
			end else if (stall_left != 0) begin
				stall_left   <= stall_left - 1;
				res_ch.ready <= (stall_left == 1);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		build_stimulus();
		n_total = pending_reqs.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// Every request yields exactly one result
		while (n_results < n_total) @(posedge clk);
		repeat (40) @(posedge clk);
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* labeled_hue_sat_histogram_unit.f */
sv/lhsh_pkg.sv
sv/lhsh_if.sv
sv/lhsh_ram.sv
sv/labeled_hue_sat_histogram_unit.sv
bench/tb_labeled_hue_sat_histogram_unit.sv
